@@ hw/rtl/rgr_pkg.sv @@
// Shared types, constants and helper functions for the Garner reconstruction block.
package rgr_pkg;

   localparam int MaxModuli = 4;
   localparam int IdxW      = (MaxModuli > 1) ? $clog2(MaxModuli) : 1;
   localparam int WordW     = 64;
   localparam int WideW     = WordW * MaxModuli;
   localparam int CountW    = 3;
   localparam int CsrIdxW   = 3;
   localparam int BitCntW   = $clog2(WordW);

   localparam logic [CsrIdxW-1:0] CsrCount = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrModA  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrModB  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrModC  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrModD  = 3'd4;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RED_R,
      OP_RED_C,
      OP_RED_A,
      OP_EUC,
      OP_MUL_DIG,
      OP_RED_DIG,
      OP_MUL_RC,
      OP_RED_RCI,
      OP_RED_M,
      OP_MUL_PP,
      OP_WMAC,
      OP_WMUL,
      OP_ADV,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_FIN,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      op_type          op;
      logic            go;
      logic [IdxW-1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic            done;
      logic            r1_zero;
      logic            k_top;
      logic            last_item;
      logic            last_word;
      logic [IdxW-1:0] k;
   } sts_type;

   // A modulus register holding zero behaves as modulus one.
   function automatic logic [WordW-1:0] eff_mod(input logic [WordW-1:0] m);
      eff_mod = (m == '0) ? WordW'(1) : m;
   endfunction

   function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] c);
      logic [CountW-1:0] r;
      r = c;
      if (c == '0) begin
         r = CountW'(1);
      end else if (c > CountW'(MaxModuli)) begin
         r = CountW'(MaxModuli);
      end
      clamp_count = r;
   endfunction

endpackage

@@ hw/rtl/rgr_modunit.sv @@
// Bit-serial unit for modular reduction, division with quotient folding and modular multiply.
module rgr_modunit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic                    div_mode,
   input  logic [rgr_pkg::WordW-1:0] d,
   input  logic [rgr_pkg::WordW-1:0] v,
   input  logic [rgr_pkg::WordW-1:0] m,
   input  logic [rgr_pkg::WordW-1:0] f,
   output logic [rgr_pkg::WordW-1:0] rem,
   output logic [rgr_pkg::WordW-1:0] acc,
   output logic                    done
);
   import rgr_pkg::*;

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [BitCntW-1:0] cnt_ff, cnt_in;
   logic [WordW-1:0]   d_ff, d_in;
   logic [WordW-1:0]   rem_ff, rem_in;
   logic [WordW-1:0]   acc_ff, acc_in;

   logic [WordW:0] r2, a2, a2r, s;
   logic           ge, qb;

   always_comb begin
      r2  = {rem_ff, d_ff[WordW-1]};
      ge  = r2 >= {1'b0, v};
      qb  = div_mode ? ge : d_ff[WordW-1];
      a2  = {acc_ff, 1'b0};
      a2r = (a2 >= {1'b0, m}) ? (a2 - {1'b0, m}) : a2;
      s   = {1'b0, a2r[WordW-1:0]} + (qb ? {1'b0, f} : '0);
      s   = (s >= {1'b0, m}) ? (s - {1'b0, m}) : s;

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         d_in   = d;
         rem_in = '0;
         acc_in = '0;
      end else if (run_ff) begin
         d_in   = {d_ff[WordW-2:0], 1'b0};
         rem_in = ge ? WordW'(r2 - {1'b0, v}) : r2[WordW-1:0];
         acc_in = s[WordW-1:0];
         cnt_in = cnt_ff + BitCntW'(1);
         if (cnt_ff == BitCntW'(WordW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      d_ff   <= d_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign rem  = rem_ff;
   assign acc  = acc_ff;
   assign done = done_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset) go |-> !run_ff)
      else $error("modular unit started while running");

endmodule

@@ hw/rtl/rgr_wideunit.sv @@
// Bit-serial wide multiplier of a multi-word value by one 64-bit factor.
module rgr_wideunit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [rgr_pkg::WideW-1:0] src,
   input  logic [rgr_pkg::WordW-1:0] f,
   output logic [rgr_pkg::WideW-1:0] res,
   output logic                      done
);
   import rgr_pkg::*;

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [BitCntW-1:0] cnt_ff, cnt_in;
   logic [WordW-1:0]   f_ff, f_in;
   logic [WideW-1:0]   res_ff, res_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      f_in    = f_ff;
      res_in  = res_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         f_in   = f;
         res_in = '0;
      end else if (run_ff) begin
         res_in = {res_ff[WideW-2:0], 1'b0} + (f_ff[WordW-1] ? src : '0);
         f_in   = {f_ff[WordW-2:0], 1'b0};
         cnt_in = cnt_ff + BitCntW'(1);
         if (cnt_ff == BitCntW'(WordW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      f_ff   <= f_in;
      res_ff <= res_in;
   end

   assign res  = res_ff;
   assign done = done_ff;

endmodule

@@ hw/rtl/rgr_datapath.sv @@
// Datapath: configuration and coefficient state, operand selection and the arithmetic units.
module rgr_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  rgr_pkg::cmd_type            cmd,
   output rgr_pkg::sts_type            sts,
   input  logic [rgr_pkg::WordW-1:0]   req_residue,
   input  logic                        csr_valid,
   input  logic [rgr_pkg::CsrIdxW-1:0] csr_index,
   input  logic [rgr_pkg::WordW-1:0]   csr_data,
   output logic                        rsp_valid,
   output logic [rgr_pkg::WordW-1:0]   rsp_out_word,
   output logic                        rsp_last_word
);
   import rgr_pkg::*;

   logic [CountW-1:0] count_ff;
   logic [WordW-1:0]  mod_ff [4];
   logic [IdxW-1:0]   index_ff;
   logic [WordW-1:0]  rc_ff  [MaxModuli];
   logic [WordW-1:0]  ppm_ff [MaxModuli];
   logic [WideW-1:0]  wpp_ff, accw_ff;
   logic [WordW-1:0]  res_ff, mk_ff, rr_ff, tmp_ff, digit_ff, x_ff, y_ff;
   logic [WordW-1:0]  r0_ff, r1_ff, t0_ff, t1_ff;
   logic              rsp_valid_ff;
   logic [WordW-1:0]  rsp_word_ff;
   logic              rsp_last_ff;

   logic [IdxW-1:0]   sel_idx;
   logic [WordW-1:0]  mi, sel_mod, inv, rc_sel, ppm_sel;
   logic [CountW-1:0] count_eff;
   logic              is_wide, div_mode, mu_go, wu_go, mu_done, wu_done, last_word;
   logic [WordW-1:0]  mu_d, mu_v, mu_m, mu_f, mu_rem, mu_acc;
   logic [WideW-1:0]  wu_res;
   logic [WordW:0]    addsum;

   always_comb begin
      sel_idx   = ((cmd.op == OP_LOAD) || (cmd.op == OP_RED_C) || (cmd.op == OP_RED_A)) ?
                  index_ff : cmd.sel;
      sel_mod   = mod_ff[sel_idx];
      mi        = eff_mod(sel_mod);
      rc_sel    = rc_ff[sel_idx];
      ppm_sel   = ppm_ff[sel_idx];
      inv       = (r0_ff == WordW'(1)) ? t0_ff : '0;
      count_eff = clamp_count(count_ff);
      last_word = (CountW'(cmd.sel) + CountW'(1)) == count_eff;
      is_wide   = (cmd.op == OP_WMAC) || (cmd.op == OP_WMUL);
      mu_go     = cmd.go && !is_wide;
      wu_go     = cmd.go && is_wide;
      addsum    = {1'b0, mu_rem} + {1'b0, y_ff};
      addsum    = (addsum >= {1'b0, mi}) ? (addsum - {1'b0, mi}) : addsum;

      div_mode = 1'b1;
      mu_d     = res_ff;
      mu_v     = mk_ff;
      mu_m     = mk_ff;
      mu_f     = '0;
      case (cmd.op)
         OP_RED_C: begin
            mu_d = rc_sel;
         end
         OP_RED_A: begin
            mu_d = ppm_sel;
         end
         OP_EUC: begin
            mu_d = r0_ff;
            mu_v = r1_ff;
            mu_f = t1_ff;
         end
         OP_MUL_DIG: begin
            div_mode = 1'b0;
            mu_d     = inv;
            mu_f     = tmp_ff;
         end
         OP_RED_DIG: begin
            mu_d = digit_ff;
            mu_v = mi;
         end
         OP_MUL_RC, OP_MUL_PP: begin
            div_mode = 1'b0;
            mu_d     = ppm_sel;
            mu_f     = x_ff;
            mu_m     = mi;
         end
         OP_RED_RCI: begin
            mu_d = rc_sel;
            mu_v = mi;
         end
         OP_RED_M: begin
            mu_d = mk_ff;
            mu_v = mi;
         end
         default: begin
            mu_d = res_ff;
         end
      endcase
   end

   rgr_modunit u_modunit (
      .clock    (clock),
      .reset    (reset),
      .go       (mu_go),
      .div_mode (div_mode),
      .d        (mu_d),
      .v        (mu_v),
      .m        (mu_m),
      .f        (mu_f),
      .rem      (mu_rem),
      .acc      (mu_acc),
      .done     (mu_done)
   );

   rgr_wideunit u_wideunit (
      .clock (clock),
      .reset (reset),
      .go    (wu_go),
      .src   (wpp_ff),
      .f     ((cmd.op == OP_WMAC) ? digit_ff : mk_ff),
      .res   (wu_res),
      .done  (wu_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountW'(1);
         for (int j = 0; j < 4; j++) begin
            mod_ff[j] <= WordW'(2);
         end
      end else if (csr_valid) begin
         case (csr_index)
            CsrCount: count_ff  <= csr_data[CountW-1:0];
            CsrModA:  mod_ff[0] <= csr_data;
            CsrModB:  mod_ff[1] <= csr_data;
            CsrModC:  mod_ff[2] <= csr_data;
            CsrModD:  mod_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.op == OP_CLEAR)) begin
         index_ff <= '0;
         for (int j = 0; j < MaxModuli; j++) begin
            rc_ff[j]  <= '0;
            ppm_ff[j] <= WordW'(1);
         end
         wpp_ff  <= WideW'(1);
         accw_ff <= '0;
      end else begin
         if (cmd.op == OP_ADV) begin
            index_ff <= index_ff + IdxW'(1);
         end
         if (mu_done && (cmd.op == OP_RED_RCI)) begin
            rc_ff[sel_idx] <= addsum[WordW-1:0];
         end
         if (mu_done && (cmd.op == OP_MUL_PP)) begin
            ppm_ff[sel_idx] <= mu_acc;
         end
         if (wu_done && (cmd.op == OP_WMAC)) begin
            accw_ff <= accw_ff + wu_res;
         end
         if (wu_done && (cmd.op == OP_WMUL)) begin
            wpp_ff <= wu_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         res_ff <= req_residue;
         mk_ff  <= mi;
      end
      if (mu_done) begin
         case (cmd.op)
            OP_RED_R: rr_ff <= mu_rem;
            OP_RED_C: tmp_ff <= (rr_ff >= mu_rem) ? (rr_ff - mu_rem) : (mk_ff - mu_rem + rr_ff);
            OP_RED_A: begin
               r0_ff <= mk_ff;
               r1_ff <= mu_rem;
               t0_ff <= '0;
               t1_ff <= (mk_ff == WordW'(1)) ? '0 : WordW'(1);
            end
            OP_EUC: begin
               r0_ff <= r1_ff;
               r1_ff <= mu_rem;
               t0_ff <= t1_ff;
               t1_ff <= t0_ff - mu_acc + ((t0_ff < mu_acc) ? mk_ff : '0);
            end
            OP_MUL_DIG: digit_ff <= mu_acc;
            OP_RED_DIG: x_ff <= mu_rem;
            OP_MUL_RC:  y_ff <= mu_acc;
            OP_RED_M:   x_ff <= mu_rem;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == OP_EMIT);
      end
      if (cmd.op == OP_EMIT) begin
         rsp_word_ff <= accw_ff[cmd.sel * WordW +: WordW];
         rsp_last_ff <= last_word;
      end
   end

   always_comb begin
      sts.done      = mu_done || wu_done;
      sts.r1_zero   = (r1_ff == '0);
      sts.k_top     = (index_ff == IdxW'(MaxModuli - 1));
      sts.last_item = (CountW'(index_ff) + CountW'(1)) >= count_eff;
      sts.last_word = last_word;
      sts.k         = index_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_word  = rsp_word_ff;
   assign rsp_last_word = rsp_last_ff;

   a_gap_after_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |=> !rsp_valid_ff)
      else $error("word strobed right after the final word");
   a_clear_index : assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_CLEAR |=> index_ff == '0)
      else $error("residue index not cleared");
   a_strobe_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.op == OP_EMIT))
      else $error("word strobed without an emit command");

endmodule

@@ hw/rtl/rgr_ctrl.sv @@
// Controller state machine that sequences the operations for each residue.
module rgr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output rgr_pkg::cmd_type cmd,
   input  rgr_pkg::sts_type sts
);
   import rgr_pkg::*;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [IdxW-1:0] i_ff, i_in;
   logic [IdxW-1:0] w_ff, w_in;
   logic            skip_euc;

   assign skip_euc = (op_ff == OP_EUC) && sts.r1_zero;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      i_in     = i_ff;
      w_in     = w_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = OP_RED_R;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (skip_euc) begin
               op_in = OP_MUL_DIG;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.done) begin
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_RED_R: op_in = OP_RED_C;
                  OP_RED_C: op_in = OP_RED_A;
                  OP_RED_A: op_in = OP_EUC;
                  OP_EUC:   op_in = OP_EUC;
                  OP_MUL_DIG: begin
                     if (sts.k_top) begin
                        op_in = OP_WMAC;
                     end else begin
                        i_in  = sts.k + IdxW'(1);
                        op_in = OP_RED_DIG;
                     end
                  end
                  OP_RED_DIG: op_in = OP_MUL_RC;
                  OP_MUL_RC:  op_in = OP_RED_RCI;
                  OP_RED_RCI: op_in = OP_RED_M;
                  OP_RED_M:   op_in = OP_MUL_PP;
                  OP_MUL_PP: begin
                     if (i_ff == IdxW'(MaxModuli - 1)) begin
                        op_in = OP_WMAC;
                     end else begin
                        i_in  = i_ff + IdxW'(1);
                        op_in = OP_RED_DIG;
                     end
                  end
                  OP_WMAC: op_in = OP_WMUL;
                  OP_WMUL: begin
                     w_in     = '0;
                     state_in = sts.last_item ? ST_EMIT : ST_FIN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (sts.last_word) begin
               state_in = ST_CLEAR;
            end else begin
               w_in = w_ff + IdxW'(1);
            end
         end
         ST_CLEAR: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op  = OP_NONE;
      cmd.go  = 1'b0;
      cmd.sel = i_ff;
      busy    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            cmd.op = start ? OP_LOAD : OP_NONE;
         end
         ST_ISSUE: begin
            cmd.op = op_ff;
            cmd.go = !skip_euc;
         end
         ST_WAIT: begin
            cmd.op = op_ff;
         end
         ST_FIN: begin
            cmd.op = OP_ADV;
         end
         ST_EMIT: begin
            cmd.op  = OP_EMIT;
            cmd.sel = w_ff;
         end
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_NONE;
         i_ff     <= '0;
         w_ff     <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         i_ff     <= i_in;
         w_ff     <= w_in;
      end
   end

   a_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      sts.done |-> state_ff == ST_WAIT)
      else $error("unit finished outside the wait state");

endmodule

@@ hw/rtl/rns_garner_reconstruct.sv @@
// Top level of the Garner mixed-radix reconstruction block.
// The block rebuilds one integer from its residues, one residue word per start.
// A residue is taken on req_residue at a rising edge where start is high and
// busy is low; residues of one coefficient come in modulus order.
// After the last residue of a coefficient the block strobes rsp_valid for one
// cycle per result word, least significant word first, with rsp_last_word on
// the final one; words follow on consecutive cycles and the receiver cannot
// hold them off, so it must take each word in the cycle it is shown.
// Configuration is written through csr_valid, csr_index and csr_data; register
// 0 is the modulus count and registers 1 to 4 are the moduli. csr_ready is
// always high, and writes are to be made only while busy is low.
// Each residue takes a series of bit-serial passes of one shared modular unit:
// three reductions, one pass per extended Euclid step (up to about 93 steps),
// one multiply, five passes for each later modulus, then two passes of the
// wide multiplier.
// On the final residue the closing state is replaced by the emit state, one
// word per cycle, and a clearing state; a word shows the cycle after its emit.
// Reset sets the count to one, all moduli to two and clears the coefficient.
module rns_garner_reconstruct (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rgr_pkg::WordW-1:0]   req_residue,
   output logic                        rsp_valid,
   output logic [rgr_pkg::WordW-1:0]   rsp_out_word,
   output logic                        rsp_last_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rgr_pkg::CsrIdxW-1:0] csr_index,
   input  logic [rgr_pkg::WordW-1:0]   csr_data
);
   import rgr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rgr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   rgr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_residue   (req_residue),
      .csr_valid     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_out_word  (rsp_out_word),
      .rsp_last_word (rsp_last_word)
   );

endmodule
